### hdl/assert_macros.svh
// assertion macros used by the top level of the packed simd alu
// no dependencies; defining SYNTH turns every macro into nothing
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
`define ASSERT_EQUAL(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) == (rhs)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, pre, post)
`define ASSERT_EQUAL(label, clk, rst, lhs, rhs)
`endif

`endif

### hdl/psa_pkg.sv
// types and operation codes of the packed simd alu
// no dependencies; used by every module of the block
package psa_pkg;

  typedef enum logic [3:0] {
    CMD_ADD8     = 4'd0,
    CMD_ADD16    = 4'd1,
    CMD_SUB8     = 4'd2,
    CMD_SUB16    = 4'd3,
    CMD_MUL16_LO = 4'd4,
    CMD_MUL16_HI = 4'd5,
    CMD_MUL8_HI  = 4'd6,
    CMD_MUL8_LO  = 4'd7
  } cmd_t;

  localparam int unsigned LANES8  = 4;
  localparam int unsigned LANES16 = 2;

  typedef struct packed {
    logic [3:0]  command;
    logic [31:0] source_a;
    logic [31:0] source_b;
  } in_t;

  typedef struct packed {
    logic [31:0] result_word;
    logic        invalid_command;
  } out_t;

  // stage 1 to lane unit
  typedef struct packed {
    logic        valid;
    logic [3:0]  command;
    logic [31:0] source_a;
    logic [31:0] source_b;
  } issue_t;

  // lane unit to pack stage
  typedef struct packed {
    logic        valid;
    logic [3:0]  command;
    logic [LANES8-1:0][15:0] prod;
    logic [LANES8-1:0][7:0]  sum8;
    logic [LANES16-1:0][15:0] sum16;
  } lane_t;

endpackage

### hdl/psa_lane_unit.sv
// lane arithmetic stage: four signed 8x8 multipliers and the add/sub lanes
// depends on psa_pkg
module psa_lane_unit (
  input  logic            clk,
  input  logic            rst,
  input  psa_pkg::issue_t issue,
  output psa_pkg::lane_t  lanes
);

  logic sub;
  logic [psa_pkg::LANES8-1:0][15:0] prod_next;
  logic [psa_pkg::LANES8-1:0][7:0]  sum8_next;
  logic [psa_pkg::LANES16-1:0][15:0] sum16_next;

  assign sub = (issue.command == psa_pkg::CMD_SUB8) || (issue.command == psa_pkg::CMD_SUB16);

  for (genvar k = 0; k < psa_pkg::LANES8; k++) begin : g_byte
    logic signed [7:0]  xa;
    logic signed [7:0]  xb;
    logic signed [15:0] p;
    assign xa = issue.source_a[8*k +: 8];
    assign xb = issue.source_b[8*k +: 8];
    // sign-extended operands; the signed product always fits in 16 bits
    assign p  = 16'(xa) * 16'(xb);
    assign prod_next[k] = p;
    assign sum8_next[k] = sub ? (issue.source_a[8*k +: 8] - issue.source_b[8*k +: 8])
                              : (issue.source_a[8*k +: 8] + issue.source_b[8*k +: 8]);
  end

  for (genvar k = 0; k < psa_pkg::LANES16; k++) begin : g_half
    assign sum16_next[k] = sub ? (issue.source_a[16*k +: 16] - issue.source_b[16*k +: 16])
                               : (issue.source_a[16*k +: 16] + issue.source_b[16*k +: 16]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lanes.valid <= 1'b0;
    end else begin
      lanes.valid <= issue.valid;
    end
    lanes.command <= issue.command;
    lanes.prod    <= prod_next;
    lanes.sum8    <= sum8_next;
    lanes.sum16   <= sum16_next;
  end

endmodule

### hdl/psa_pack.sv
// output stage: picks and packs the lane results by operation code
// depends on psa_pkg
module psa_pack (
  input  logic           clk,
  input  logic           rst,
  input  psa_pkg::lane_t lanes,
  output logic           done,
  output psa_pkg::out_t  result
);

  psa_pkg::out_t result_next;

  always_comb begin
    result_next.invalid_command = 1'b0;
    case (lanes.command)
      psa_pkg::CMD_ADD8, psa_pkg::CMD_SUB8: begin
        result_next.result_word = lanes.sum8;
      end
      psa_pkg::CMD_ADD16, psa_pkg::CMD_SUB16: begin
        result_next.result_word = lanes.sum16;
      end
      psa_pkg::CMD_MUL16_LO: begin
        result_next.result_word = {lanes.prod[1], lanes.prod[0]};
      end
      psa_pkg::CMD_MUL16_HI: begin
        result_next.result_word = {lanes.prod[3], lanes.prod[2]};
      end
      psa_pkg::CMD_MUL8_HI: begin
        result_next.result_word = {lanes.prod[3][15:8], lanes.prod[2][15:8],
                                   lanes.prod[1][15:8], lanes.prod[0][15:8]};
      end
      psa_pkg::CMD_MUL8_LO: begin
        result_next.result_word = {lanes.prod[3][7:0], lanes.prod[2][7:0],
                                   lanes.prod[1][7:0], lanes.prod[0][7:0]};
      end
      default: begin
        result_next.result_word     = '0;
        result_next.invalid_command = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= lanes.valid;
    end
    result <= result_next;
  end

endmodule

### hdl/packed_simd_alu.sv
// packed simd alu top level: issue register, lane unit, pack stage
// depends on psa_pkg, psa_lane_unit, psa_pack and assert_macros.svh
//
// Takes one command per clock: busy is always low, so a beat is accepted at
// every edge with start high. Each result appears after all three register
// stages, for one cycle with done high, in issue order. The three register
// stages are the issue register, the lane unit (four signed 8x8 multipliers
// and the add/sub lanes) and the output pack register; there is no state
// between commands. Unknown codes give a zero word with invalid_command set.
`include "assert_macros.svh"

module packed_simd_alu (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  psa_pkg::in_t  operands,
  output logic          done,
  output psa_pkg::out_t result
);

  psa_pkg::issue_t issue;
  psa_pkg::lane_t  lanes;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      issue.valid <= 1'b0;
    end else begin
      issue.valid <= start && !busy;
    end
    issue.command  <= operands.command;
    issue.source_a <= operands.source_a;
    issue.source_b <= operands.source_b;
  end

  psa_lane_unit u_lane (
    .clk   (clk),
    .rst   (rst),
    .issue (issue),
    .lanes (lanes)
  );

  psa_pack u_pack (
    .clk    (clk),
    .rst    (rst),
    .lanes  (lanes),
    .done   (done),
    .result (result)
  );

  // every beat comes out after the issue, lane and pack registers
  `ASSERT_EQUAL(a_latency, clk, rst, done, ($past(start, 3) && !$past(rst, 3) && !$past(rst, 2) && !$past(rst, 1)))
  `ASSERT_IMPLIES(a_invalid_zero, clk, rst, done && result.invalid_command, result.result_word == 32'd0)
  `ASSERT_IMPLIES(a_invalid_code, clk, rst, done, result.invalid_command == $past(operands.command[3], 3))

endmodule

### bench/tb_packed_simd_alu.sv
// self-checking bench for packed_simd_alu: directed corners, then random commands
// depends on psa_pkg and the packed_simd_alu rtl; the scoreboard predicts each lane result
module tb_packed_simd_alu;

  localparam logic [3:0] CMD_FIRST_UNKNOWN = 4'd8;
  localparam logic [3:0] CMD_LAST_UNKNOWN  = 4'd15;
  localparam int         RANDOM_BEATS      = 1625;
  localparam int         DRAIN_CYCLES      = 8;
  localparam int         PRINT_CAP         = 40;

  class simd_scoreboard;
    psa_pkg::out_t expected_words[$];
    int            mismatches;

    function psa_pkg::out_t lane_math(psa_pkg::in_t op);
      psa_pkg::out_t       r;
      logic signed [15:0]  prod [4];
      r.result_word     = '0;
      r.invalid_command = 1'b0;
      for (int k = 0; k < 4; k++)
        prod[k] = 16'($signed(op.source_a[8*k +: 8])) * 16'($signed(op.source_b[8*k +: 8]));
      case (op.command)
        psa_pkg::CMD_ADD8:
          for (int k = 0; k < 4; k++)
            r.result_word[8*k +: 8] = op.source_a[8*k +: 8] + op.source_b[8*k +: 8];
        psa_pkg::CMD_ADD16:
          for (int k = 0; k < 2; k++)
            r.result_word[16*k +: 16] = op.source_a[16*k +: 16] + op.source_b[16*k +: 16];
        psa_pkg::CMD_SUB8:
          for (int k = 0; k < 4; k++)
            r.result_word[8*k +: 8] = op.source_a[8*k +: 8] - op.source_b[8*k +: 8];
        psa_pkg::CMD_SUB16:
          for (int k = 0; k < 2; k++)
            r.result_word[16*k +: 16] = op.source_a[16*k +: 16] - op.source_b[16*k +: 16];
        psa_pkg::CMD_MUL16_LO: r.result_word = {prod[1], prod[0]};
        psa_pkg::CMD_MUL16_HI: r.result_word = {prod[3], prod[2]};
        psa_pkg::CMD_MUL8_HI:
          for (int k = 0; k < 4; k++)
            r.result_word[8*k +: 8] = prod[k][15:8];
        psa_pkg::CMD_MUL8_LO:
          for (int k = 0; k < 4; k++)
            r.result_word[8*k +: 8] = prod[k][7:0];
        default: r.invalid_command = 1'b1;
      endcase
      return r;
    endfunction

    function void note_beat(psa_pkg::in_t op);
      expected_words.push_back(lane_math(op));
    endfunction

    function void check_beat(psa_pkg::out_t got);
      psa_pkg::out_t want;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= PRINT_CAP)
          $display("%0t: result beat with nothing pending, got %h/%b", $time,
                   got.result_word, got.invalid_command);
        return;
      end
      want = expected_words.pop_front();
      if (got.result_word !== want.result_word) begin
        mismatches++;
        if (mismatches <= PRINT_CAP)
          $display("%0t: result_word expected %h got %h", $time,
                   want.result_word, got.result_word);
      end
      if (got.invalid_command !== want.invalid_command) begin
        mismatches++;
        if (mismatches <= PRINT_CAP)
          $display("%0t: invalid_command expected %b got %b", $time,
                   want.invalid_command, got.invalid_command);
      end
    endfunction

    function int pending_count();
      return expected_words.size();
    endfunction
  endclass

  logic          clk;
  logic          rst;
  logic          start;
  logic          busy;
  psa_pkg::in_t  operands;
  logic          done;
  psa_pkg::out_t result;

  simd_scoreboard sb = new();

  packed_simd_alu dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .operands (operands),
    .done     (done),
    .result   (result)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // accept and check on the same edge; a beat is noted before any result is checked
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_beat(operands);
      if (done) sb.check_beat(result);
    end
  end

  function automatic logic [31:0] corner_word();
    logic [31:0] w;
    w = '0;
    case ($urandom_range(0, 2))
      0: w = $urandom;
      1:
        for (int k = 0; k < 4; k++)
          case ($urandom_range(0, 6))
            0: w[8*k +: 8] = 8'h00;
            1: w[8*k +: 8] = 8'h01;
            2: w[8*k +: 8] = 8'h7f;
            3: w[8*k +: 8] = 8'h80;
            4: w[8*k +: 8] = 8'h81;
            5: w[8*k +: 8] = 8'hff;
            default: w[8*k +: 8] = 8'($urandom_range(0, 255));
          endcase
      default:
        for (int k = 0; k < 2; k++)
          case ($urandom_range(0, 6))
            0: w[16*k +: 16] = 16'h0000;
            1: w[16*k +: 16] = 16'h0001;
            2: w[16*k +: 16] = 16'h7fff;
            3: w[16*k +: 16] = 16'h8000;
            4: w[16*k +: 16] = 16'h8001;
            5: w[16*k +: 16] = 16'hffff;
            default: w[16*k +: 16] = 16'($urandom_range(0, 65535));
          endcase
    endcase
    return w;
  endfunction

  function automatic int pick_gap();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 65) return 0;
    if (r < 93) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 40));
  endfunction

  // called at a falling edge; returns at the falling edge after the beat is taken
  task automatic issue_beat(input logic [3:0] cmd, input logic [31:0] a, input logic [31:0] b);
    psa_pkg::in_t op;
    op.command  = cmd;
    op.source_a = a;
    op.source_b = b;
    start    <= 1'b1;
    operands <= op;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic idle_gap(input int cycles);
    psa_pkg::in_t junk;
    if (cycles == 0) return;
    junk.command  = 4'($urandom_range(0, 15));
    junk.source_a = $urandom;
    junk.source_b = $urandom;
    start    <= 1'b0;
    operands <= junk;
    repeat (cycles) @(negedge clk);
  endtask

  initial begin
    logic [3:0] cmd;
    bit         no_gaps;
    rst      = 1'b1;
    start    = 1'b0;
    operands = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // lane wrap, products of the most negative operands and borrow through every lane
    for (int c = int'(psa_pkg::CMD_ADD8); c <= int'(psa_pkg::CMD_MUL8_LO); c++) begin
      issue_beat(4'(c), 32'hffff_ffff, 32'h0101_0101);
      issue_beat(4'(c), 32'h8080_8080, 32'h8080_8080);
      issue_beat(4'(c), 32'h0000_0000, 32'h7fff_ff81);
    end
    issue_beat(CMD_FIRST_UNKNOWN, 32'hffff_ffff, 32'hffff_ffff);
    issue_beat(CMD_LAST_UNKNOWN, 32'h1234_5678, 32'h8765_4321);
    idle_gap(3);

    no_gaps = 1'b0;
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (i % 64 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0)
        cmd = 4'($urandom_range(CMD_FIRST_UNKNOWN, CMD_LAST_UNKNOWN));
      else
        cmd = 4'($urandom_range(psa_pkg::CMD_ADD8, psa_pkg::CMD_MUL8_LO));
      issue_beat(cmd, corner_word(), corner_word());
      if (!no_gaps) idle_gap(pick_gap());
    end
    idle_gap(1);

    while (sb.pending_count() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_count() == 0)
      $display("packed_simd_alu: match");
    else
      $display("packed_simd_alu: mismatch");
    $finish;
  end

  initial begin
    #2000000;
    $display("packed_simd_alu: mismatch");
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/psa_pkg.sv
hdl/psa_lane_unit.sv
hdl/psa_pack.sv
hdl/packed_simd_alu.sv
bench/tb_packed_simd_alu.sv
